@@ rtl/gsph_pkg.sv @@
// Shared types, codes and constants for the gamepad serial poll host.
`timescale 1ns / 1ps
`default_nettype none

package gsph_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SETUP,
    PH_LOW,
    PH_HIGH,
    PH_BGAP,
    PH_FGAP
  } phase_t;

  typedef enum logic [1:0] {
    REQ_NONE,
    REQ_POLL,
    REQ_ANALOG,
    REQ_DIGITAL
  } req_t;

  localparam logic [7:0] DELAY_RESET   = 8'd10;
  localparam logic [7:0] ID_ANALOG     = 8'h73;
  localparam logic [7:0] STICK_NEUTRAL = 8'h80;
  localparam logic [7:0] CMD_START     = 8'h01;
  localparam logic [7:0] CMD_POLL      = 8'h42;
  localparam logic [7:0] CMD_CONFIG    = 8'h43;
  localparam logic [7:0] CMD_MODE      = 8'h44;
  localparam logic [7:0] MODE_LOCK     = 8'h03;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;
  localparam logic [7:0] BYTE_ONE      = 8'h01;

  // Byte sent at a given position of a frame.
  function automatic logic [7:0] tx_byte(input req_t kind, input logic [3:0] byte_idx,
                                         input logic [1:0] frame_idx);
    logic [7:0] b;
    b = BYTE_ZERO;
    if (byte_idx == 4'd0) begin
      b = CMD_START;
    end else if (kind == REQ_POLL) begin
      b = (byte_idx == 4'd1) ? CMD_POLL : BYTE_ZERO;
    end else if (byte_idx == 4'd1) begin
      b = (frame_idx == 2'd1) ? CMD_MODE : CMD_CONFIG;
    end else if (byte_idx == 4'd3) begin
      if (frame_idx == 2'd0) begin
        b = BYTE_ONE;
      end else if (frame_idx == 2'd1) begin
        b = (kind == REQ_ANALOG) ? BYTE_ONE : BYTE_ZERO;
      end
    end else if (byte_idx == 4'd4 && frame_idx == 2'd1) begin
      b = MODE_LOCK;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/gsph_if.sv @@
// Valid/ready channel interfaces for the tick inputs and the line/result outputs.
`timescale 1ns / 1ps
`default_nettype none

interface gsph_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic       data_line;

  modport source (output valid, output req_type, output data_line, input ready);
  modport sink (input valid, input req_type, input data_line, output ready);
endinterface

interface gsph_out_if;
  logic        valid;
  logic        ready;
  logic        clock_line;
  logic        command_line;
  logic        attention_line;
  logic        busy_res;
  logic        poll_done;
  logic [15:0] buttons;
  logic [7:0]  right_x;
  logic [7:0]  right_y;
  logic [7:0]  left_x;
  logic [7:0]  left_y;
  logic        analog_seen;

  modport source (output valid, output clock_line, output command_line,
                  output attention_line, output busy_res, output poll_done,
                  output buttons, output right_x, output right_y, output left_x,
                  output left_y, output analog_seen, input ready);
  modport sink (input valid, input clock_line, input command_line,
                input attention_line, input busy_res, input poll_done,
                input buttons, input right_x, input right_y, input left_x,
                input left_y, input analog_seen, output ready);
endinterface

`default_nettype wire

@@ rtl/gamepad_serial_poll_host.sv @@
// Gamepad serial link host: tick-driven line sequencer with result registers.
//
// Each beat on in_if is one timebase tick: a request code (taken only while
// the sequencer is idle) and the sampled controller data line. Each tick
// produces exactly one beat on out_if carrying the clock, command and
// attention line levels, busy and poll-done flags, and the button, stick and
// analog-id results as they stand after that tick.
// A tick beat is captured in an input register, the sequencer step runs on
// it once the output register can take a result, and its result lands in
// the output register. One tick is taken every cycle while out_if is ready;
// the output register lets a new tick enter while a finished result waits,
// and a stall on out_if holds the result and, once the input register is
// also full, drops in_if.ready.
// cfg_we writes bit_delay (reset 10) from cfg_wdata; it should only change
// while the sequencer is idle. After reset the sequencer is idle, the sticks
// read 0x80 and buttons read zero.
`timescale 1ns / 1ps
`default_nettype none

module gamepad_serial_poll_host (
  input  wire logic       clk,
  input  wire logic       rst_n,
  gsph_in_if.sink         in_if,
  gsph_out_if.source      out_if,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata
);

  // Configuration
  logic [7:0] bit_delay_r;

  // Input stage
  logic       in_valid_r;
  logic [1:0] in_req_r;
  logic       in_din_r;

  // Sequencer state
  gsph_pkg::phase_t phase_r, phase_c, phase_nxt;
  gsph_pkg::req_t   kind_r, kind_c, kind_nxt;
  logic [11:0] wait_r, wait_c, wait_nxt;
  logic [2:0]  bit_r, bit_c, bit_nxt;
  logic [3:0]  byte_r, byte_c, byte_nxt;
  logic [1:0]  frame_r, frame_c, frame_nxt;
  logic [7:0]  rcv_r, rcv_c, rcv_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [15:0] btn_r, btn_nxt;
  logic [7:0]  stick_r [4];
  logic [7:0]  stick_nxt [4];

  // Output register
  logic        out_valid_r;
  logic        clk_line_r, cmd_line_r, att_line_r, busy_r, done_r;

  logic        advance;
  logic [7:0]  eff_delay;
  logic [11:0] eff_wait, half_wait, dbl_wait, ten_wait, wait_dec;
  gsph_pkg::phase_t setup_phase;
  logic [11:0] setup_wait;
  logic [7:0]  cur_tx;
  logic        clk_c, cmd_c, att_c, busy_c, done_c, last_byte;

  assign advance     = in_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !in_valid_r || advance;

  assign eff_delay = (bit_delay_r == 8'd0) ? 8'd1 : bit_delay_r;
  assign eff_wait  = {4'd0, eff_delay};
  assign half_wait = {5'd0, eff_delay[7:1]};
  assign dbl_wait  = {3'd0, eff_delay, 1'b0};
  assign ten_wait  = {1'b0, eff_delay, 3'd0} + {3'd0, eff_delay, 1'b0};

  // With D of 1 the setup half-phase is empty and the bit starts clock-low.
  assign setup_phase = (half_wait == 12'd0) ? gsph_pkg::PH_LOW : gsph_pkg::PH_SETUP;
  assign setup_wait  = (half_wait == 12'd0) ? eff_wait : half_wait;

  // A request taken from idle starts its first frame within the same tick.
  always_comb begin
    phase_c = phase_r;
    kind_c  = kind_r;
    wait_c  = wait_r;
    bit_c   = bit_r;
    byte_c  = byte_r;
    frame_c = frame_r;
    rcv_c   = rcv_r;
    if (phase_r == gsph_pkg::PH_IDLE && gsph_pkg::req_t'(in_req_r) != gsph_pkg::REQ_NONE) begin
      kind_c  = gsph_pkg::req_t'(in_req_r);
      frame_c = 2'd0;
      byte_c  = 4'd0;
      bit_c   = 3'd0;
      rcv_c   = 8'd0;
      phase_c = setup_phase;
      wait_c  = setup_wait;
    end
  end

  assign cur_tx   = gsph_pkg::tx_byte(kind_c, byte_c, frame_c);
  assign wait_dec = (wait_c != 12'd0) ? (wait_c - 12'd1) : 12'd0;

  always_comb begin
    if (kind_c == gsph_pkg::REQ_POLL) begin
      last_byte = (byte_c == 4'd4 && id_r != gsph_pkg::ID_ANALOG) || byte_c >= 4'd8;
    end else begin
      last_byte = byte_c >= 4'd8;
    end
  end

  always_comb begin
    phase_nxt = phase_c;
    kind_nxt  = kind_c;
    wait_nxt  = wait_c;
    bit_nxt   = bit_c;
    byte_nxt  = byte_c;
    frame_nxt = frame_c;
    rcv_nxt   = rcv_c;
    id_nxt    = id_r;
    btn_nxt   = btn_r;
    stick_nxt = stick_r;
    clk_c     = 1'b1;
    cmd_c     = 1'b1;
    att_c     = 1'b1;
    busy_c    = 1'b0;
    done_c    = 1'b0;

    case (phase_c)
      gsph_pkg::PH_IDLE: begin
        phase_nxt = gsph_pkg::PH_IDLE;
      end
      gsph_pkg::PH_SETUP, gsph_pkg::PH_LOW, gsph_pkg::PH_HIGH,
      gsph_pkg::PH_BGAP, gsph_pkg::PH_FGAP: begin
        busy_c = 1'b1;
        if (phase_c == gsph_pkg::PH_SETUP || phase_c == gsph_pkg::PH_LOW ||
            phase_c == gsph_pkg::PH_HIGH) begin
          cmd_c = cur_tx[bit_c];
        end
        clk_c    = (phase_c != gsph_pkg::PH_LOW);
        att_c    = (phase_c == gsph_pkg::PH_FGAP);
        wait_nxt = wait_dec;
        if (wait_dec == 12'd0) begin
          case (phase_c)
            gsph_pkg::PH_SETUP: begin
              phase_nxt = gsph_pkg::PH_LOW;
              wait_nxt  = eff_wait;
            end
            gsph_pkg::PH_LOW: begin
              rcv_nxt[bit_c] = in_din_r;
              phase_nxt      = gsph_pkg::PH_HIGH;
              wait_nxt       = eff_wait;
            end
            gsph_pkg::PH_HIGH: begin
              if (bit_c != 3'd7) begin
                bit_nxt   = bit_c + 3'd1;
                phase_nxt = setup_phase;
                wait_nxt  = setup_wait;
              end else begin
                bit_nxt = 3'd0;
                if (kind_c == gsph_pkg::REQ_POLL) begin
                  case (byte_c)
                    4'd1: id_nxt = rcv_c;
                    4'd3: btn_nxt[7:0] = ~rcv_c;
                    4'd4: btn_nxt[15:8] = ~rcv_c;
                    4'd5: stick_nxt[0] = rcv_c;
                    4'd6: stick_nxt[1] = rcv_c;
                    4'd7: stick_nxt[2] = rcv_c;
                    4'd8: stick_nxt[3] = rcv_c;
                    default: ;
                  endcase
                end
                phase_nxt = gsph_pkg::PH_BGAP;
                wait_nxt  = dbl_wait;
              end
            end
            gsph_pkg::PH_BGAP: begin
              if (last_byte) begin
                if (kind_c == gsph_pkg::REQ_POLL) begin
                  if (id_r != gsph_pkg::ID_ANALOG) begin
                    stick_nxt[0] = gsph_pkg::STICK_NEUTRAL;
                    stick_nxt[1] = gsph_pkg::STICK_NEUTRAL;
                    stick_nxt[2] = gsph_pkg::STICK_NEUTRAL;
                    stick_nxt[3] = gsph_pkg::STICK_NEUTRAL;
                  end
                  done_c   = 1'b1;
                  wait_nxt = ten_wait;
                end else begin
                  wait_nxt = eff_wait;
                end
                phase_nxt = gsph_pkg::PH_FGAP;
              end else begin
                byte_nxt  = byte_c + 4'd1;
                phase_nxt = setup_phase;
                wait_nxt  = setup_wait;
              end
            end
            default: begin
              // Frame gap: mode requests run three frames, a poll runs one.
              if (kind_c != gsph_pkg::REQ_POLL && frame_c < 2'd2) begin
                frame_nxt = frame_c + 2'd1;
                byte_nxt  = 4'd0;
                bit_nxt   = 3'd0;
                rcv_nxt   = 8'd0;
                phase_nxt = setup_phase;
                wait_nxt  = setup_wait;
              end else begin
                phase_nxt = gsph_pkg::PH_IDLE;
              end
            end
          endcase
        end
      end
      default: begin
        phase_nxt = gsph_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_delay_r <= gsph_pkg::DELAY_RESET;
    end else if (cfg_we) begin
      bit_delay_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_req_r <= in_if.req_type;
      in_din_r <= in_if.data_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= gsph_pkg::PH_IDLE;
      kind_r     <= gsph_pkg::REQ_NONE;
      wait_r     <= 12'd0;
      bit_r      <= 3'd0;
      byte_r     <= 4'd0;
      frame_r    <= 2'd0;
      rcv_r      <= 8'd0;
      id_r       <= 8'd0;
      btn_r      <= 16'd0;
      stick_r[0] <= gsph_pkg::STICK_NEUTRAL;
      stick_r[1] <= gsph_pkg::STICK_NEUTRAL;
      stick_r[2] <= gsph_pkg::STICK_NEUTRAL;
      stick_r[3] <= gsph_pkg::STICK_NEUTRAL;
    end else if (advance) begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      wait_r  <= wait_nxt;
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      frame_r <= frame_nxt;
      rcv_r   <= rcv_nxt;
      id_r    <= id_nxt;
      btn_r   <= btn_nxt;
      stick_r <= stick_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      clk_line_r <= clk_c;
      cmd_line_r <= cmd_c;
      att_line_r <= att_c;
      busy_r     <= busy_c;
      done_r     <= done_c;
    end
  end

  // Result fields mirror the state registers, which only move with a beat.
  assign out_if.valid          = out_valid_r;
  assign out_if.clock_line     = clk_line_r;
  assign out_if.command_line   = cmd_line_r;
  assign out_if.attention_line = att_line_r;
  assign out_if.busy_res       = busy_r;
  assign out_if.poll_done      = done_r;
  assign out_if.buttons        = btn_r;
  assign out_if.right_x        = stick_r[0];
  assign out_if.right_y        = stick_r[1];
  assign out_if.left_x         = stick_r[2];
  assign out_if.left_y         = stick_r[3];
  assign out_if.analog_seen    = (id_r == gsph_pkg::ID_ANALOG);

  a_clock_low_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !clk_line_r) |-> (!att_line_r && busy_r))
    else $error("clock line low outside an active frame");

  a_empty_takes_tick: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_if.ready)
    else $error("input register empty but tick not accepted");

  a_done_enters_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && done_c) |=> (phase_r == gsph_pkg::PH_FGAP && kind_r == gsph_pkg::REQ_POLL))
    else $error("poll completion did not enter the frame gap");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && phase_c == gsph_pkg::PH_IDLE) |=> (!busy_r && att_line_r && clk_line_r))
    else $error("idle tick drove an active line level");

endmodule

`default_nettype wire
